@@ design/packet_header_checksum_deframer_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the packet header deframer core
// Shorthand for clocked, reset-qualified assertions on clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef PACKET_HEADER_CHECKSUM_DEFRAMER_CORE_ASSERT_SVH
`define PACKET_HEADER_CHECKSUM_DEFRAMER_CORE_ASSERT_SVH

// same-cycle implication
`define PHCD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pkhd same-cycle check failed");

// next-cycle implication
`define PHCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pkhd next-cycle check failed");

`endif

@@ design/pkhd_pkg.sv @@
// ----------------------------------------------------------------------------
// pkhd_pkg
// Shared constants, codes and the queue entry type of the header deframer.
// ----------------------------------------------------------------------------
package pkhd_pkg;

  localparam int unsigned HDR_BYTES    = 20;
  localparam int unsigned LANE_COUNT   = 4;
  localparam int unsigned FLAGS_OFFSET = 12;
  localparam int unsigned LEN_W        = 11;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_SHORT  = 2'd1;
  localparam logic [1:0] ST_BADSUM = 2'd2;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic             has_payload;
    logic             has_summary;
    logic [7:0]       data;
    logic [1:0]       status;
    logic [15:0]      src_port;
    logic [15:0]      dst_port;
    logic [31:0]      seq;
    logic [31:0]      ack;
    logic [7:0]       flags;
    logic [LEN_W-1:0] length;
  } pkhd_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } pkhd_qstat_t;

endpackage

@@ design/pkhd_queue.sv @@
// ----------------------------------------------------------------------------
// pkhd_queue
// Two-entry queue between the classify front and the result back.
// ----------------------------------------------------------------------------
module pkhd_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  pkhd_pkg::pkhd_entry_t push_entry,
  input  logic                 pop,
  output pkhd_pkg::pkhd_entry_t head,
  output pkhd_pkg::pkhd_qstat_t stat
);

  pkhd_pkg::pkhd_entry_t head_r, head_nxt;
  pkhd_pkg::pkhd_entry_t tail_r, tail_nxt;
  logic                  head_v_r, head_v_nxt;
  logic                  tail_v_r, tail_v_nxt;

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    head_v_nxt = head_v_r;
    tail_v_nxt = tail_v_r;
    if (pop) begin
      if (tail_v_r) begin
        head_nxt = tail_r;
        if (push) begin
          tail_nxt = push_entry;
        end else begin
          tail_v_nxt = 1'b0;
        end
      end else if (push) begin
        head_nxt = push_entry;
      end else begin
        head_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!head_v_r) begin
        head_nxt   = push_entry;
        head_v_nxt = 1'b1;
      end else begin
        tail_nxt   = push_entry;
        tail_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
    if (!rst_n) begin
      head_v_r <= 1'b0;
      tail_v_r <= 1'b0;
    end else begin
      head_v_r <= head_v_nxt;
      tail_v_r <= tail_v_nxt;
    end
  end

  assign head       = head_r;
  assign stat.full  = tail_v_r;
  assign stat.empty = !head_v_r;

endmodule

@@ design/pkhd_front.sv @@
// ----------------------------------------------------------------------------
// pkhd_front
// Accept bytes, fold them into the XOR lanes, capture the header and
// classify each byte into payload and summary work for the queue.
// ----------------------------------------------------------------------------
module pkhd_front #(
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_last_byte,
  input  pkhd_pkg::pkhd_qstat_t q_stat,
  output logic                  q_push,
  output pkhd_pkg::pkhd_entry_t q_entry
);

  localparam int unsigned POS_MAX = pkhd_pkg::HDR_BYTES + MAX_PAYLOAD;
  localparam int unsigned POS_W   = $clog2(POS_MAX + 1);
  localparam int unsigned LW      = (POS_W > pkhd_pkg::LEN_W) ? POS_W : pkhd_pkg::LEN_W;
  localparam int unsigned SEL_W   = $clog2(pkhd_pkg::LANE_COUNT);

  logic [7:0]       lane_r   [pkhd_pkg::LANE_COUNT];
  logic [7:0]       lane_nxt [pkhd_pkg::LANE_COUNT];
  logic [SEL_W-1:0] sel_r, sel_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt, pos_inc;
  logic [15:0]      src_r, src_nxt;
  logic [15:0]      dst_r, dst_nxt;
  logic [31:0]      seq_r, seq_nxt;
  logic [31:0]      ack_r, ack_nxt;
  logic [7:0]       flags_r, flags_nxt;

  logic             accept;
  logic             in_hdr;
  logic             bad;
  logic             too_short;
  logic [1:0]       status;
  logic [LW-1:0]    len_full;
  logic [7:0]       lane_upd [pkhd_pkg::LANE_COUNT];
  logic [15:0]      src_upd, dst_upd;
  logic [31:0]      seq_upd, ack_upd;
  logic [7:0]       flags_upd;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  always_comb begin
    for (int i = 0; i < pkhd_pkg::LANE_COUNT; i++) begin
      lane_upd[i] = lane_r[i];
    end
    lane_upd[sel_r] = lane_r[sel_r] ^ in_data_byte;
    bad = 1'b0;
    for (int i = 0; i < pkhd_pkg::LANE_COUNT; i++) begin
      bad = bad | (lane_upd[i] != 8'd0);
    end

    in_hdr  = pos_r < POS_W'(pkhd_pkg::HDR_BYTES);
    pos_inc = (pos_r < POS_W'(POS_MAX)) ? POS_W'(pos_r + 1'b1) : pos_r;

    src_upd   = src_r;
    dst_upd   = dst_r;
    seq_upd   = seq_r;
    ack_upd   = ack_r;
    flags_upd = flags_r;
    if (pos_r < POS_W'(2)) begin
      src_upd = {src_r[7:0], in_data_byte};
    end else if (pos_r < POS_W'(4)) begin
      dst_upd = {dst_r[7:0], in_data_byte};
    end else if (pos_r < POS_W'(8)) begin
      seq_upd = {seq_r[23:0], in_data_byte};
    end else if (pos_r < POS_W'(pkhd_pkg::FLAGS_OFFSET)) begin
      ack_upd = {ack_r[23:0], in_data_byte};
    end else if (pos_r == POS_W'(pkhd_pkg::FLAGS_OFFSET)) begin
      flags_upd = in_data_byte;
    end

    too_short = pos_inc < POS_W'(pkhd_pkg::HDR_BYTES);
    if (too_short) begin
      status = pkhd_pkg::ST_SHORT;
    end else if (bad) begin
      status = pkhd_pkg::ST_BADSUM;
    end else begin
      status = pkhd_pkg::ST_OK;
    end
    len_full = LW'(pos_inc) - LW'(pkhd_pkg::HDR_BYTES);

    q_entry.has_payload = !in_hdr;
    q_entry.has_summary = in_last_byte;
    q_entry.data        = in_data_byte;
    q_entry.status      = status;
    if (status == pkhd_pkg::ST_OK) begin
      q_entry.src_port = src_upd;
      q_entry.dst_port = dst_upd;
      q_entry.seq      = seq_upd;
      q_entry.ack      = ack_upd;
      q_entry.flags    = flags_upd;
      q_entry.length   = len_full[pkhd_pkg::LEN_W-1:0];
    end else begin
      q_entry.src_port = '0;
      q_entry.dst_port = '0;
      q_entry.seq      = '0;
      q_entry.ack      = '0;
      q_entry.flags    = '0;
      q_entry.length   = '0;
    end
    q_push = accept && (!in_hdr || in_last_byte);

    for (int i = 0; i < pkhd_pkg::LANE_COUNT; i++) begin
      lane_nxt[i] = lane_r[i];
    end
    sel_nxt   = sel_r;
    pos_nxt   = pos_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    seq_nxt   = seq_r;
    ack_nxt   = ack_r;
    flags_nxt = flags_r;
    if (accept) begin
      if (in_last_byte) begin
        for (int i = 0; i < pkhd_pkg::LANE_COUNT; i++) begin
          lane_nxt[i] = '0;
        end
        sel_nxt   = '0;
        pos_nxt   = '0;
        src_nxt   = '0;
        dst_nxt   = '0;
        seq_nxt   = '0;
        ack_nxt   = '0;
        flags_nxt = '0;
      end else begin
        for (int i = 0; i < pkhd_pkg::LANE_COUNT; i++) begin
          lane_nxt[i] = lane_upd[i];
        end
        sel_nxt   = SEL_W'(sel_r + 1'b1);
        pos_nxt   = pos_inc;
        src_nxt   = src_upd;
        dst_nxt   = dst_upd;
        seq_nxt   = seq_upd;
        ack_nxt   = ack_upd;
        flags_nxt = flags_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < pkhd_pkg::LANE_COUNT; i++) begin
        lane_r[i] <= '0;
      end
      sel_r   <= '0;
      pos_r   <= '0;
      src_r   <= '0;
      dst_r   <= '0;
      seq_r   <= '0;
      ack_r   <= '0;
      flags_r <= '0;
    end else begin
      for (int i = 0; i < pkhd_pkg::LANE_COUNT; i++) begin
        lane_r[i] <= lane_nxt[i];
      end
      sel_r   <= sel_nxt;
      pos_r   <= pos_nxt;
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
      seq_r   <= seq_nxt;
      ack_r   <= ack_nxt;
      flags_r <= flags_nxt;
    end
  end

endmodule

@@ design/pkhd_back.sv @@
// ----------------------------------------------------------------------------
// pkhd_back
// Expand queued work into payload and summary items in the output register.
// ----------------------------------------------------------------------------
module pkhd_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pkhd_pkg::pkhd_entry_t q_head,
  input  pkhd_pkg::pkhd_qstat_t q_stat,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_item_kind,
  output logic [7:0]            out_payload_byte,
  output logic [1:0]            out_status_code,
  output logic [15:0]           out_source_port,
  output logic [15:0]           out_dest_port,
  output logic [31:0]           out_seq_number,
  output logic [31:0]           out_ack_number,
  output logic [7:0]            out_flag_bits,
  output logic [10:0]           out_payload_length,
  output logic                  out_end_of_run
);

  logic        valid_r, valid_nxt;
  logic        phase_r, phase_nxt;
  logic        kind_r, kind_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [1:0]  status_r, status_nxt;
  logic [15:0] src_r, src_nxt;
  logic [15:0] dst_r, dst_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic [31:0] ack_r, ack_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [10:0] len_r, len_nxt;
  logic        eor_r, eor_nxt;
  logic        load;
  logic        emit_pay;

  assign load     = !valid_r || !out_stall;
  assign emit_pay = q_head.has_payload && !phase_r;

  always_comb begin
    q_pop      = 1'b0;
    valid_nxt  = valid_r;
    phase_nxt  = phase_r;
    kind_nxt   = kind_r;
    byte_nxt   = byte_r;
    status_nxt = status_r;
    src_nxt    = src_r;
    dst_nxt    = dst_r;
    seq_nxt    = seq_r;
    ack_nxt    = ack_r;
    flags_nxt  = flags_r;
    len_nxt    = len_r;
    eor_nxt    = eor_r;
    if (load) begin
      valid_nxt = !q_stat.empty;
      if (!q_stat.empty) begin
        if (emit_pay && q_head.has_summary) begin
          phase_nxt = 1'b1;
        end else begin
          phase_nxt = 1'b0;
          q_pop     = 1'b1;
        end
        if (emit_pay) begin
          kind_nxt   = pkhd_pkg::KIND_PAYLOAD;
          byte_nxt   = q_head.data;
          status_nxt = pkhd_pkg::ST_OK;
          src_nxt    = '0;
          dst_nxt    = '0;
          seq_nxt    = '0;
          ack_nxt    = '0;
          flags_nxt  = '0;
          len_nxt    = '0;
          eor_nxt    = 1'b0;
        end else begin
          kind_nxt   = pkhd_pkg::KIND_SUMMARY;
          byte_nxt   = '0;
          status_nxt = q_head.status;
          src_nxt    = q_head.src_port;
          dst_nxt    = q_head.dst_port;
          seq_nxt    = q_head.seq;
          ack_nxt    = q_head.ack;
          flags_nxt  = q_head.flags;
          len_nxt    = q_head.length;
          eor_nxt    = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    byte_r   <= byte_nxt;
    status_r <= status_nxt;
    src_r    <= src_nxt;
    dst_r    <= dst_nxt;
    seq_r    <= seq_nxt;
    ack_r    <= ack_nxt;
    flags_r  <= flags_nxt;
    len_r    <= len_nxt;
    eor_r    <= eor_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  assign out_valid          = valid_r;
  assign out_item_kind      = kind_r;
  assign out_payload_byte   = byte_r;
  assign out_status_code    = status_r;
  assign out_source_port    = src_r;
  assign out_dest_port      = dst_r;
  assign out_seq_number     = seq_r;
  assign out_ack_number     = ack_r;
  assign out_flag_bits      = flags_r;
  assign out_payload_length = len_r;
  assign out_end_of_run     = eor_r;

endmodule

@@ design/packet_header_checksum_deframer_core.sv @@
// Flow: a result passes through the queue register and then the output register
// once its byte is accepted. Throughput: 1 byte per cycle while in_stall is low; a final
// byte inside the payload yields two items in the output register, absorbed by the 2-entry queue.
// Reset: synchronous active-low rst_n clears the lanes, byte counter, header
// registers, queue and output valid at once; no clearing pass.
// ----------------------------------------------------------------------------
// packet_header_checksum_deframer_core
// Byte-serial header parser with a four-lane interleaved XOR checksum.
// ----------------------------------------------------------------------------
`include "packet_header_checksum_deframer_core_assert.svh"

module packet_header_checksum_deframer_core #(
  parameter int unsigned MAX_PAYLOAD = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_item_kind,
  output logic [7:0]  out_payload_byte,
  output logic [1:0]  out_status_code,
  output logic [15:0] out_source_port,
  output logic [15:0] out_dest_port,
  output logic [31:0] out_seq_number,
  output logic [31:0] out_ack_number,
  output logic [7:0]  out_flag_bits,
  output logic [10:0] out_payload_length,
  output logic        out_end_of_run
);

  logic                  q_push;
  logic                  q_pop;
  pkhd_pkg::pkhd_entry_t q_entry;
  pkhd_pkg::pkhd_entry_t q_head;
  pkhd_pkg::pkhd_qstat_t q_stat;

  pkhd_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_entry      (q_entry)
  );

  pkhd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .stat       (q_stat)
  );

  pkhd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_head             (q_head),
    .q_stat             (q_stat),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_item_kind      (out_item_kind),
    .out_payload_byte   (out_payload_byte),
    .out_status_code    (out_status_code),
    .out_source_port    (out_source_port),
    .out_dest_port      (out_dest_port),
    .out_seq_number     (out_seq_number),
    .out_ack_number     (out_ack_number),
    .out_flag_bits      (out_flag_bits),
    .out_payload_length (out_payload_length),
    .out_end_of_run     (out_end_of_run)
  );

  `PHCD_ASSERT_SAME(a_pop_nonempty, q_pop, !q_stat.empty)
  `PHCD_ASSERT_NEXT(a_full_holds, q_stat.full && !q_pop, q_stat.full)
  `PHCD_ASSERT_SAME(a_bad_zeroed, out_valid && out_item_kind == pkhd_pkg::KIND_SUMMARY && out_status_code != pkhd_pkg::ST_OK, out_payload_length == 11'd0 && out_seq_number == 32'd0)
  `PHCD_ASSERT_SAME(a_payload_clean, out_valid && out_item_kind == pkhd_pkg::KIND_PAYLOAD, !out_end_of_run && out_status_code == pkhd_pkg::ST_OK)

endmodule

@@ dv/packet_header_checksum_deframer_core_tb.sv @@
// ----------------------------------------------------------------------------
// packet_header_checksum_deframer_core_tb
// Self-checking bench for the byte-serial header deframer. Frames of random
// content are sent byte by byte, sealed with a matching four-lane XOR where
// the frame should pass. Short frames, corrupted sums, raw noise and one
// oversized frame are also sent. An in-bench parser predicts every payload
// byte and frame summary, and each accepted output item is compared field
// by field. Both sides idle at random, with quiet stretches in between.
// ----------------------------------------------------------------------------
module packet_header_checksum_deframer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_PAYLOAD_BYTES = 1024;
  localparam int unsigned RANDOM_ITEMS      = 370;
  localparam int unsigned DRAIN_CYCLES      = 8;
  localparam int unsigned CYCLE_LIMIT       = 600000;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload;
    logic [1:0]  status;
    logic [15:0] src;
    logic [15:0] dst;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [7:0]  flags;
    logic [10:0] len;
    logic        eor;
  } deframe_result_t;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic        out_item_kind;
  logic [7:0]  out_payload_byte;
  logic [1:0]  out_status_code;
  logic [15:0] out_source_port;
  logic [15:0] out_dest_port;
  logic [31:0] out_seq_number;
  logic [31:0] out_ack_number;
  logic [7:0]  out_flag_bits;
  logic [10:0] out_payload_length;
  logic        out_end_of_run;

  logic [7:0]  lane_xor [pkhd_pkg::LANE_COUNT];
  logic [10:0] byte_cnt;
  logic [1:0]  lane_idx;
  logic [15:0] src_q;
  logic [15:0] dst_q;
  logic [31:0] seq_q;
  logic [31:0] ack_q;
  logic [7:0]  flags_q;

  deframe_result_t deframed_items [$];
  logic [7:0]      frame_buf [$];

  bit          quiet = 1'b0;
  int          fail_count = 0;
  int          sent_items = 0;
  int          frames_sent = 0;
  int          results_checked = 0;
  int          rx_gap;
  int          stall_left = 0;
  int unsigned cycle_count = 0;

  packet_header_checksum_deframer_core #(
    .MAX_PAYLOAD(MAX_PAYLOAD_BYTES)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_item_kind     (out_item_kind),
    .out_payload_byte  (out_payload_byte),
    .out_status_code   (out_status_code),
    .out_source_port   (out_source_port),
    .out_dest_port     (out_dest_port),
    .out_seq_number    (out_seq_number),
    .out_ack_number    (out_ack_number),
    .out_flag_bits     (out_flag_bits),
    .out_payload_length(out_payload_length),
    .out_end_of_run    (out_end_of_run)
  );

  always #5ns clk = ~clk;

  function automatic int draw_gap();
    return quiet ? 0 : int'($urandom_range(0, 16));
  endfunction

  function automatic void clear_parser();
    for (int i = 0; i < pkhd_pkg::LANE_COUNT; i++) lane_xor[i] = 8'h00;
    byte_cnt = '0;
    lane_idx = '0;
    src_q    = '0;
    dst_q    = '0;
    seq_q    = '0;
    ack_q    = '0;
    flags_q  = '0;
  endfunction

  function automatic void deframe_byte(logic [7:0] d, logic last);
    deframe_result_t r;
    logic [10:0]     pos;
    logic            bad;
    pos = byte_cnt;
    lane_xor[lane_idx] ^= d;
    lane_idx = lane_idx + 2'd1;
    if (pos < pkhd_pkg::HDR_BYTES) begin
      if (pos < 2) src_q = {src_q[7:0], d};
      else if (pos < 4) dst_q = {dst_q[7:0], d};
      else if (pos < 8) seq_q = {seq_q[23:0], d};
      else if (pos < pkhd_pkg::FLAGS_OFFSET) ack_q = {ack_q[23:0], d};
      else if (pos == pkhd_pkg::FLAGS_OFFSET) flags_q = d;
    end else begin
      r = '0;
      r.kind = pkhd_pkg::KIND_PAYLOAD;
      r.payload = d;
      deframed_items.push_back(r);
    end
    if (pos < pkhd_pkg::HDR_BYTES + MAX_PAYLOAD_BYTES) byte_cnt = pos + 11'd1;
    if (last) begin
      bad = 1'b0;
      for (int i = 0; i < pkhd_pkg::LANE_COUNT; i++)
        if (lane_xor[i] != 8'h00) bad = 1'b1;
      r = '0;
      r.kind = pkhd_pkg::KIND_SUMMARY;
      r.eor = 1'b1;
      if (byte_cnt < pkhd_pkg::HDR_BYTES) r.status = pkhd_pkg::ST_SHORT;
      else if (bad) r.status = pkhd_pkg::ST_BADSUM;
      else begin
        r.status = pkhd_pkg::ST_OK;
        r.src    = src_q;
        r.dst    = dst_q;
        r.seq    = seq_q;
        r.ack    = ack_q;
        r.flags  = flags_q;
        r.len    = 11'(byte_cnt - pkhd_pkg::HDR_BYTES);
      end
      deframed_items.push_back(r);
      clear_parser();
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  function automatic void check_result();
    deframe_result_t exp_r;
    results_checked++;
    if (deframed_items.size() == 0) begin
      $display("%0t unexpected item: expected none actual kind %0d byte %0h",
               $time, out_item_kind, out_payload_byte);
      fail_count++;
      return;
    end
    exp_r = deframed_items.pop_front();
    check_field("item_kind", exp_r.kind, out_item_kind);
    check_field("payload_byte", exp_r.payload, out_payload_byte);
    check_field("status_code", exp_r.status, out_status_code);
    check_field("source_port", exp_r.src, out_source_port);
    check_field("dest_port", exp_r.dst, out_dest_port);
    check_field("seq_number", exp_r.seq, out_seq_number);
    check_field("ack_number", exp_r.ack, out_ack_number);
    check_field("flag_bits", exp_r.flags, out_flag_bits);
    check_field("payload_length", exp_r.len, out_payload_length);
    check_field("end_of_run", exp_r.eor, out_end_of_run);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      check_result();
      rx_gap = draw_gap();
      stall_left <= rx_gap;
      out_stall  <= (rx_gap != 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t timeout with %0d items outstanding", $time, deframed_items.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] d, input logic last);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= d;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    deframe_byte(d, last);
    sent_items++;
  endtask

  function automatic void fill_frame(int len);
    frame_buf.delete();
    for (int i = 0; i < len; i++) frame_buf.push_back(8'($urandom_range(0, 255)));
  endfunction

  // cancel every lane through the four bytes just before the payload
  function automatic void seal_frame();
    logic [7:0] acc [pkhd_pkg::LANE_COUNT];
    int         base;
    base = pkhd_pkg::HDR_BYTES - pkhd_pkg::LANE_COUNT;
    for (int l = 0; l < pkhd_pkg::LANE_COUNT; l++) acc[l] = 8'h00;
    for (int i = 0; i < frame_buf.size(); i++)
      if (i < base || i >= pkhd_pkg::HDR_BYTES)
        acc[i % pkhd_pkg::LANE_COUNT] ^= frame_buf[i];
    for (int l = 0; l < pkhd_pkg::LANE_COUNT; l++) frame_buf[base + l] = acc[l];
  endfunction

  function automatic void corrupt_frame();
    int k;
    k = $urandom_range(0, frame_buf.size() - 1);
    frame_buf[k] = frame_buf[k] ^ (8'h01 << $urandom_range(0, 7));
  endfunction

  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++)
      send_byte(frame_buf[i], i == frame_buf.size() - 1);
    frames_sent++;
  endtask

  task automatic test_short_frames();
    frame_buf = '{8'h00};
    send_frame();
    frame_buf = '{8'hFF};
    send_frame();
    fill_frame(pkhd_pkg::HDR_BYTES - 1);
    send_frame();
  endtask

  task automatic test_header_extremes();
    fill_frame(pkhd_pkg::HDR_BYTES);
    for (int i = 0; i <= pkhd_pkg::FLAGS_OFFSET; i++) frame_buf[i] = 8'hFF;
    seal_frame();
    send_frame();
    fill_frame(pkhd_pkg::HDR_BYTES);
    for (int i = 0; i < pkhd_pkg::HDR_BYTES; i++) frame_buf[i] = 8'h00;
    seal_frame();
    send_frame();
  endtask

  task automatic test_checksum_and_payload();
    fill_frame(pkhd_pkg::HDR_BYTES + 4);
    seal_frame();
    send_frame();
    fill_frame(pkhd_pkg::HDR_BYTES + 2);
    seal_frame();
    corrupt_frame();
    send_frame();
    fill_frame(pkhd_pkg::HDR_BYTES);
    seal_frame();
    corrupt_frame();
    send_frame();
  endtask

  task automatic test_long_frame();
    fill_frame(pkhd_pkg::HDR_BYTES + MAX_PAYLOAD_BYTES + 6);
    seal_frame();
    send_frame();
  endtask

  task automatic test_random_traffic();
    int stop_at;
    int sel;
    int n;
    stop_at = sent_items + RANDOM_ITEMS;
    while (sent_items < stop_at) begin
      if ($urandom_range(0, 7) == 0) quiet = ~quiet;
      sel = $urandom_range(0, 9);
      if (sel < 8) begin
        if ($urandom_range(0, 5) == 0) n = $urandom_range(0, 120);
        else n = $urandom_range(0, 12);
        fill_frame(pkhd_pkg::HDR_BYTES + n);
        seal_frame();
        if (sel == 7) corrupt_frame();
        send_frame();
      end else if (sel == 8) begin
        fill_frame($urandom_range(1, pkhd_pkg::HDR_BYTES - 1));
        send_frame();
      end else begin
        n = $urandom_range(1, 30);
        for (int i = 0; i < n; i++)
          send_byte(8'($urandom_range(0, 255)), i == n - 1 || $urandom_range(0, 7) == 0);
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    clear_parser();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_short_frames();
    test_header_extremes();
    test_checksum_and_payload();
    test_long_frame();
    test_random_traffic();
    in_valid <= 1'b0;
    while (deframed_items.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d bytes in %0d frames plus noise; checked %0d output items",
             sent_items, frames_sent, results_checked);
    $display("covered short, bad-sum, sealed, header-extreme and saturated-length frames");
    if (fail_count == 0 && deframed_items.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
